### hw/rtl/lph_pkg.sv
// ----------------------------------------------------------------------------
// lph_pkg
// Shared constants, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int OPC_W     = 3;
  localparam int STAT_W    = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_THR    = 1'd1;

  localparam logic [CFG_W-1:0] PROBE_LIMIT_RST = 7'd8;
  localparam logic [CFG_W-1:0] LOAD_THR_RST    = 7'd48;

  // opcodes
  localparam logic [OPC_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OPC_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OPC_W-1:0] OP_WRITE  = 3'd2;
  localparam logic [OPC_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OPC_W-1:0] OP_SCAN   = 3'd5;

  // result status
  localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [STAT_W-1:0] ST_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  // operation class handed from front to back
  typedef enum logic [2:0] {
    CLS_LOOKUP = 3'd0,
    CLS_INSERT = 3'd1,
    CLS_WRITE  = 3'd2,
    CLS_REMOVE = 3'd3,
    CLS_CLEAR  = 3'd4,
    CLS_SCAN   = 3'd5,
    CLS_NOP    = 3'd6
  } op_cls_t;

endpackage

### hw/rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing key/value table with linear probing and backward-shift
// removal; front decode and hash, two-entry queue, sequential back end.
// ----------------------------------------------------------------------------
// One beat in, one result beat out. The back end handles one item at a time and
// its table memories have a registered read port, so each probed slot takes a
// read state and a compare state, and a hit adds a read and a hit state. Remove
// then pulls later cluster entries back into the hole one by one and frees the
// last hole. Clear and an unknown opcode go straight to the result. A scan
// examines slots one at a time from slot_index and reads the entry it finds. The
// front reduces the key mod SLOTS one hex digit at a time unless SLOTS is a power
// of two, and runs ahead of the back end through the queue. Results wait in an
// output register; while it holds a result not yet taken, the back end holds the
// finished item and takes no new one.
module linear_probe_hash_table #(
  parameter int SLOTS      = lph_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF,
  localparam int SLOT_W    = $clog2(SLOTS),
  localparam int CNT_W     = $clog2(SLOTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lph_pkg::OPC_W-1:0]     opcode,
  input  logic [KEY_BITS-1:0]           key,
  input  logic [VALUE_BITS-1:0]         store_value,
  input  logic [SLOT_W-1:0]             slot_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lph_pkg::STAT_W-1:0]    status,
  output logic [VALUE_BITS-1:0]         value_out,
  output logic [KEY_BITS-1:0]           key_out,
  output logic [SLOT_W-1:0]             slot_out,
  output logic                          rehash_wanted,
  output logic [CNT_W-1:0]              entry_count,
  input  logic                          cfg_we,
  input  logic [lph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lph_pkg::CFG_W-1:0]     cfg_data
);

  localparam int QW = 3 + KEY_BITS + VALUE_BITS + 2 * SLOT_W;

  logic          push_valid;
  logic          push_ready;
  logic [QW-1:0] push_data;
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;

  lph_front #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .key         (key),
    .store_value (store_value),
    .slot_index  (slot_index),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  lph_queue #(
    .W (QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  lph_back #(
    .SLOTS      (SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .value_out     (value_out),
    .key_out       (key_out),
    .slot_out      (slot_out),
    .rehash_wanted (rehash_wanted),
    .entry_count   (entry_count)
  );

endmodule

### hw/rtl/lph_queue.sv
// ----------------------------------------------------------------------------
// lph_queue
// Two-entry FIFO between the decode front and the execution back end.
// ----------------------------------------------------------------------------
module lph_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;

  logic do_push;
  logic do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/lph_front.sv
// ----------------------------------------------------------------------------
// lph_front
// Takes input beats, decodes the opcode and computes the home slot
// (key mod SLOTS), one hex digit per cycle unless SLOTS is a power of two.
// ----------------------------------------------------------------------------
module lph_front #(
  parameter int SLOTS      = lph_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF,
  localparam int SLOT_W    = $clog2(SLOTS),
  localparam int QW        = 3 + KEY_BITS + VALUE_BITS + 2 * SLOT_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [lph_pkg::OPC_W-1:0] opcode,
  input  logic [KEY_BITS-1:0]     key,
  input  logic [VALUE_BITS-1:0]   store_value,
  input  logic [SLOT_W-1:0]       slot_index,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic [QW-1:0]           push_data
);

  localparam bit POW2   = (SLOTS & (SLOTS - 1)) == 0;
  localparam int EXT_W  = (KEY_BITS > SLOT_W) ? KEY_BITS : SLOT_W;
  localparam int DIG_N  = (EXT_W + 3) / 4;
  localparam int PAD_W  = DIG_N * 4;
  localparam int DIG_W  = $clog2(DIG_N);
  localparam int T_W    = SLOT_W + 4;
  localparam logic [T_W-1:0] M_T = T_W'(SLOTS);

  logic                  full;
  logic                  done;
  lph_pkg::op_cls_t      cls;
  lph_pkg::op_cls_t      cls_next;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] nv_q;
  logic [SLOT_W-1:0]     sidx_q;
  logic [SLOT_W-1:0]     rem;
  logic [DIG_W-1:0]      dig;
  logic [PAD_W-1:0]      key_pad;
  logic [PAD_W-1:0]      key_in_pad;
  logic [3:0]            digit;

  // r*16 + d reduced mod SLOTS; input stays below 16*SLOTS
  function automatic logic [SLOT_W-1:0] mod_step(input logic [SLOT_W-1:0] r,
                                                  input logic [3:0] d);
    logic [T_W-1:0] t;
    t = {r, d};
    for (int i = 3; i >= 0; i--) begin
      if (t >= (M_T << i)) begin
        t = t - (M_T << i);
      end
    end
    return t[SLOT_W-1:0];
  endfunction

  always_comb begin
    unique case (opcode)
      lph_pkg::OP_LOOKUP: cls_next = lph_pkg::CLS_LOOKUP;
      lph_pkg::OP_INSERT: cls_next = lph_pkg::CLS_INSERT;
      lph_pkg::OP_WRITE:  cls_next = lph_pkg::CLS_WRITE;
      lph_pkg::OP_REMOVE: cls_next = lph_pkg::CLS_REMOVE;
      lph_pkg::OP_CLEAR:  cls_next = lph_pkg::CLS_CLEAR;
      lph_pkg::OP_SCAN:   cls_next = lph_pkg::CLS_SCAN;
      default:            cls_next = lph_pkg::CLS_NOP;
    endcase
  end

  assign key_in_pad = PAD_W'(key);
  assign key_pad    = PAD_W'(key_q);
  // most significant digit first
  assign digit      = key_pad[(PAD_W - 4 - 4 * int'(dig)) +: 4];

  assign in_ready   = !full;
  assign push_valid = full && done;
  assign push_data  = {cls, key_q, nv_q, sidx_q, rem};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cls    <= cls_next;
      key_q  <= key;
      nv_q   <= store_value;
      sidx_q <= slot_index;
      dig    <= '0;
      rem    <= POW2 ? key_in_pad[SLOT_W-1:0] : '0;
    end else if (full && !done) begin
      rem <= mod_step(rem, digit);
      dig <= dig + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      done <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        full <= 1'b1;
        done <= POW2;
      end else if (full && !done) begin
        if (dig == DIG_W'(DIG_N - 1)) begin
          done <= 1'b1;
        end
      end else if (push_valid && push_ready) begin
        full <= 1'b0;
        done <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/lph_back.sv
// ----------------------------------------------------------------------------
// lph_back
// Executes table operations: probe walk, insert, write, backward-shift
// remove, clear and occupied-slot scan, with the result output register.
// ----------------------------------------------------------------------------
module lph_back #(
  parameter int SLOTS      = lph_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lph_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lph_pkg::VALUE_BITS_DEF,
  localparam int SLOT_W    = $clog2(SLOTS),
  localparam int CNT_W     = $clog2(SLOTS + 1),
  localparam int QW        = 3 + KEY_BITS + VALUE_BITS + 2 * SLOT_W
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic [QW-1:0]                 q_data,
  input  logic                          cfg_we,
  input  logic [lph_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lph_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lph_pkg::STAT_W-1:0]    status,
  output logic [VALUE_BITS-1:0]         value_out,
  output logic [KEY_BITS-1:0]           key_out,
  output logic [SLOT_W-1:0]             slot_out,
  output logic                          rehash_wanted,
  output logic [CNT_W-1:0]              entry_count
);

  localparam int CMP_W = (CNT_W > lph_pkg::CFG_W) ? CNT_W : lph_pkg::CFG_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_PRD    = 12'b000000000010,
    ST_PCMP   = 12'b000000000100,
    ST_HRD    = 12'b000000001000,
    ST_HIT    = 12'b000000010000,
    ST_SCAN   = 12'b000000100000,
    ST_SRD    = 12'b000001000000,
    ST_RSTART = 12'b000010000000,
    ST_RSTEP  = 12'b000100000000,
    ST_RWAIT  = 12'b001000000000,
    ST_RCMP   = 12'b010000000000,
    ST_DONE   = 12'b100000000000
  } state_t;

  state_t state;

  // item fields
  logic [2:0]            q_cls_raw;
  lph_pkg::op_cls_t      q_cls;
  logic [KEY_BITS-1:0]   q_key;
  logic [VALUE_BITS-1:0] q_nv;
  logic [SLOT_W-1:0]     q_sidx;
  logic [SLOT_W-1:0]     q_home;

  lph_pkg::op_cls_t      cls;
  logic [KEY_BITS-1:0]   it_key;
  logic [VALUE_BITS-1:0] it_nv;
  logic [SLOT_W-1:0]     it_home;

  // table state
  logic [KEY_BITS-1:0]   key_mem   [SLOTS];
  logic [SLOT_W-1:0]     home_mem  [SLOTS];
  logic [VALUE_BITS-1:0] value_mem [SLOTS];
  logic [SLOTS-1:0]      occ;
  logic                  zkv;
  logic [SLOT_W-1:0]     zks;
  logic [CNT_W-1:0]      count;
  logic                  rehash;
  logic [lph_pkg::CFG_W-1:0] probe_limit;
  logic [lph_pkg::CFG_W-1:0] load_thr;

  // walk registers
  logic [SLOT_W-1:0]     s;
  logic [SLOT_W-1:0]     n;
  logic [SLOT_W-1:0]     hole;
  logic [SLOT_W-1:0]     first_hole;

  // registered read data at slot s
  logic [KEY_BITS-1:0]   kdat;
  logic [SLOT_W-1:0]     hdat;
  logic [VALUE_BITS-1:0] vdat;

  // pending result
  logic [lph_pkg::STAT_W-1:0] r_status;
  logic [VALUE_BITS-1:0]      r_val;
  logic [KEY_BITS-1:0]        r_key;
  logic [SLOT_W-1:0]          r_slot;

  // combinational decisions
  logic [KEY_BITS-1:0]   k_cur;
  logic                  key_eq;
  logic                  k_zero;
  logic                  p_hit;
  logic                  p_empty;
  logic [SLOT_W-1:0]     p_pos;
  logic                  is_ins;
  logic                  move;
  logic [SLOT_W-1:0]     s_nxt;
  logic                  r_stop;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  flag_ins;
  logic                  flag_rem;
  logic                  out_free;

  logic                  kw_en;
  logic [SLOT_W-1:0]     kw_addr;
  logic [KEY_BITS-1:0]   kw_key;
  logic [SLOT_W-1:0]     kw_home;
  logic                  vw_en;
  logic [SLOT_W-1:0]     vw_addr;
  logic [VALUE_BITS-1:0] vw_data;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] a);
    return (a == LAST_SLOT) ? '0 : a + 1'b1;
  endfunction

  // (a - b) mod SLOTS
  function automatic logic [SLOT_W-1:0] run_len(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] d;
    if (a >= b) begin
      d = {1'b0, a} - {1'b0, b};
    end else begin
      d = {1'b0, a} + (SLOT_W + 1)'(SLOTS) - {1'b0, b};
    end
    return d[SLOT_W-1:0];
  endfunction

  function automatic logic run_flag(input logic cur, input logic [CNT_W-1:0] cnt,
                                    input logic [SLOT_W-1:0] run,
                                    input logic [lph_pkg::CFG_W-1:0] thr,
                                    input logic [lph_pkg::CFG_W-1:0] lim);
    logic trip;
    trip = (CMP_W'(cnt) >= CMP_W'(thr)) &&
           ((CMP_W + SLOT_W)'(run) > (CMP_W + SLOT_W)'(lim));
    return cur || trip;
  endfunction

  assign {q_cls_raw, q_key, q_nv, q_sidx, q_home} = q_data;
  assign q_cls   = lph_pkg::op_cls_t'(q_cls_raw);
  assign q_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    k_cur   = occ[s] ? kdat : '0;
    key_eq  = (k_cur == it_key);
    k_zero  = (k_cur == '0);
    p_hit   = key_eq && (!k_zero || zkv);
    p_empty = key_eq ? (k_zero && !zkv) : (k_zero && !(zkv && zks == s));
    p_pos   = (key_eq && k_zero) ? zks : s;
    is_ins  = (cls == lph_pkg::CLS_INSERT) || (cls == lph_pkg::CLS_WRITE);
    // hole lies cyclically within [home of s, s]
    if (s >= hdat) begin
      move = (hole >= hdat) && (hole <= s);
    end else begin
      move = (hole >= hdat) || (hole <= s);
    end
    s_nxt    = next_slot(s);
    r_stop   = (s_nxt == first_hole) || !occ[s_nxt];
    cnt_inc  = count + 1'b1;
    cnt_dec  = (count != '0) ? count - 1'b1 : '0;
    flag_ins = run_flag(rehash, cnt_inc, run_len(s, it_home), load_thr, probe_limit);
    flag_rem = run_flag(rehash, cnt_dec, run_len(s_nxt, first_hole), load_thr,
                        probe_limit);
  end

  always_comb begin
    kw_en   = 1'b0;
    kw_addr = hole;
    kw_key  = kdat;
    kw_home = hdat;
    vw_en   = 1'b0;
    vw_addr = hole;
    vw_data = vdat;
    unique case (state)
      ST_PCMP: begin
        if (!p_hit && p_empty && is_ins) begin
          kw_en   = 1'b1;
          kw_addr = s;
          kw_key  = it_key;
          kw_home = it_home;
          vw_en   = 1'b1;
          vw_addr = s;
          vw_data = (cls == lph_pkg::CLS_WRITE) ? it_nv : '0;
        end
      end
      ST_HIT: begin
        if (cls == lph_pkg::CLS_WRITE) begin
          vw_en   = 1'b1;
          vw_addr = s;
          vw_data = it_nv;
        end
      end
      ST_RCMP: begin
        if (move) begin
          kw_en = 1'b1;
          vw_en = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // table memories: one write, one registered read at s
  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr]  <= kw_key;
      home_mem[kw_addr] <= kw_home;
    end
    kdat <= key_mem[s];
    hdat <= home_mem[s];
  end

  always_ff @(posedge clk) begin
    if (vw_en) begin
      value_mem[vw_addr] <= vw_data;
    end
    vdat <= value_mem[s];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_limit <= lph_pkg::PROBE_LIMIT_RST;
      load_thr    <= lph_pkg::LOAD_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lph_pkg::REG_PROBE_LIMIT: probe_limit <= cfg_data;
        lph_pkg::REG_LOAD_THR:    load_thr    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // item payload and walk registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cls      <= q_cls;
        it_key   <= q_key;
        it_nv    <= q_nv;
        it_home  <= q_home;
        n        <= '0;
        r_status <= lph_pkg::ST_MISS;
        r_val    <= '0;
        r_key    <= '0;
        r_slot   <= '0;
        if (q_cls == lph_pkg::CLS_SCAN) begin
          s <= q_sidx;
        end else begin
          s <= q_home;
        end
        if (q_cls == lph_pkg::CLS_CLEAR) begin
          r_status <= lph_pkg::ST_FOUND;
        end
      end
      ST_PCMP: begin
        if (p_hit) begin
          s <= p_pos;
        end else if (p_empty) begin
          if (is_ins) begin
            r_status <= lph_pkg::ST_INSERTED;
            r_val    <= (cls == lph_pkg::CLS_WRITE) ? it_nv : '0;
            r_key    <= it_key;
            r_slot   <= s;
          end
        end else if (n == LAST_SLOT) begin
          if (is_ins) begin
            r_status <= lph_pkg::ST_FULL;
          end
        end else begin
          s <= s_nxt;
          n <= n + 1'b1;
        end
      end
      ST_HIT: begin
        r_status   <= lph_pkg::ST_FOUND;
        r_val      <= (cls == lph_pkg::CLS_WRITE) ? it_nv : vdat;
        r_key      <= kdat;
        r_slot     <= s;
        hole       <= s;
        first_hole <= s;
      end
      ST_SCAN: begin
        if (!occ[s] && s != LAST_SLOT) begin
          s <= s_nxt;
        end
      end
      ST_SRD: begin
        r_status <= lph_pkg::ST_FOUND;
        r_val    <= vdat;
        r_key    <= kdat;
        r_slot   <= s;
      end
      ST_RSTART: begin
        s <= hole;
      end
      ST_RSTEP: begin
        if (!r_stop) begin
          s <= s_nxt;
        end
      end
      ST_RCMP: begin
        if (move) begin
          hole <= s;
        end
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      occ           <= '0;
      zkv           <= 1'b0;
      zks           <= '0;
      count         <= '0;
      rehash        <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_cls)
              lph_pkg::CLS_CLEAR: begin
                occ    <= '0;
                zkv    <= 1'b0;
                zks    <= '0;
                count  <= '0;
                rehash <= 1'b0;
                state  <= ST_DONE;
              end
              lph_pkg::CLS_SCAN: begin
                if ((SLOT_W + 1)'(q_sidx) >= (SLOT_W + 1)'(SLOTS)) begin
                  state <= ST_DONE;
                end else begin
                  state <= ST_SCAN;
                end
              end
              lph_pkg::CLS_NOP: state <= ST_DONE;
              default:          state <= ST_PRD;
            endcase
          end
        end
        ST_PRD: state <= ST_PCMP;
        ST_PCMP: begin
          if (p_hit) begin
            state <= ST_HRD;
          end else if (p_empty) begin
            if (is_ins) begin
              occ[s] <= 1'b1;
              count  <= cnt_inc;
              rehash <= flag_ins;
              if (it_key == '0) begin
                zkv <= 1'b1;
                zks <= s;
              end
            end
            state <= ST_DONE;
          end else if (n == LAST_SLOT) begin
            state <= ST_DONE;
          end else begin
            state <= ST_PRD;
          end
        end
        ST_HRD: state <= ST_HIT;
        ST_HIT: begin
          if (cls == lph_pkg::CLS_REMOVE) begin
            state <= ST_RSTART;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_SCAN: begin
          if (occ[s]) begin
            state <= ST_SRD;
          end else if (s == LAST_SLOT) begin
            state <= ST_DONE;
          end
        end
        ST_SRD: state <= ST_DONE;
        ST_RSTART: begin
          if (zkv && zks == hole) begin
            zkv <= 1'b0;
          end
          state <= ST_RSTEP;
        end
        ST_RSTEP: begin
          if (r_stop) begin
            occ[hole] <= 1'b0;
            count     <= cnt_dec;
            rehash    <= flag_rem;
            state     <= ST_DONE;
          end else begin
            state <= ST_RWAIT;
          end
        end
        ST_RWAIT: state <= ST_RCMP;
        ST_RCMP: begin
          if (move) begin
            if (zkv && zks == s) begin
              zks <= hole;
            end
            state <= ST_RSTART;
          end else begin
            state <= ST_RSTEP;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      status        <= r_status;
      value_out     <= r_val;
      key_out       <= r_key;
      slot_out      <= r_slot;
      rehash_wanted <= rehash;
      entry_count   <= count;
    end
  end

`ifndef ASSERT_OFF
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("back state not one-hot");

  a_count_occ: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == int'(count))
    else $error("entry count disagrees with occupied slots");

  a_zero_slot_occ: assert property (@(posedge clk) disable iff (rst)
    zkv |-> occ[zks])
    else $error("zero-key slot not occupied");

  a_rehash_sticky: assert property (@(posedge clk) disable iff (rst)
    rehash && !(state == ST_IDLE && q_valid && q_cls == lph_pkg::CLS_CLEAR) |=> rehash)
    else $error("rehash flag dropped without clear");
`endif

endmodule

### dv/lph_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lph_checker
// Watches the request, result and register ports of the hash table, keeps a
// shadow table that tracks every accepted request, and compares each result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lph_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [31:0] key,
  input  logic [31:0] store_value,
  input  logic [5:0]  slot_index,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic [31:0] value_out,
  input  logic [31:0] key_out,
  input  logic [5:0]  slot_out,
  input  logic        rehash_wanted,
  input  logic [6:0]  entry_count,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output int          errors,
  output int          outstanding
);

  typedef enum int {PRB_HIT, PRB_EMPTY, PRB_MISS, PRB_FULL} probe_res_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [31:0] key;
    logic [5:0]  slot;
    logic        rehash;
    logic [6:0]  count;
  } table_result_t;

  logic [31:0] shadow_keys[64];
  logic [31:0] shadow_vals[64];
  bit          zkey_valid;
  int          zkey_slot;
  int          fill_count;
  bit          rehash_flag;
  int          probe_limit;
  int          load_thr;

  table_result_t result_fifo[$];

  assign outstanding = result_fifo.size();

  function automatic bit zero_at(int s);
    return zkey_valid && s == zkey_slot;
  endfunction

  function automatic void run_check(int first, int last);
    if (rehash_flag || fill_count < load_thr) return;
    if (((last + 64 - first) % 64) > probe_limit) rehash_flag = 1;
  endfunction

  function automatic probe_res_t walk(logic [31:0] k, bit ins, output int pos,
                                     output int start);
    int s;
    s = int'(k % 32'd64);
    start = s;
    pos = 0;
    for (int n = 0; n < 64; n++) begin
      if (shadow_keys[s] == k) begin
        if (k == 0) begin
          if (!zkey_valid) begin
            pos = s;
            return ins ? PRB_EMPTY : PRB_MISS;
          end
          pos = zkey_slot;
        end else begin
          pos = s;
        end
        return PRB_HIT;
      end
      if (shadow_keys[s] == 0 && !zero_at(s)) begin
        pos = s;
        return ins ? PRB_EMPTY : PRB_MISS;
      end
      s = (s + 1) % 64;
    end
    return PRB_FULL;
  endfunction

  // backward-shift delete: pull later cluster members into the hole
  function automatic void shift_out(int hole);
    int first, s, home;
    bit move;
    first = hole;
    for (int outer = 0; outer <= 64; outer++) begin
      s = hole;
      move = 0;
      if (zero_at(hole)) zkey_valid = 0;
      for (int inner = 0; inner < 64; inner++) begin
        s = (s + 1) % 64;
        if (s == first || (shadow_keys[s] == 0 && !zero_at(s))) break;
        home = int'(shadow_keys[s] % 32'd64);
        if (s >= home) begin
          if (hole >= home && hole <= s) begin
            move = 1;
            break;
          end
        end else if (hole >= home || hole <= s) begin
          move = 1;
          break;
        end
      end
      if (!move) begin
        shadow_keys[hole] = 0;
        if (fill_count > 0) fill_count--;
        run_check(first, s);
        return;
      end
      if (zero_at(s)) zkey_slot = hole;
      shadow_keys[hole] = shadow_keys[s];
      shadow_vals[hole] = shadow_vals[s];
      hole = s;
    end
  endfunction

  function automatic table_result_t predict_op(logic [2:0] op, logic [31:0] k,
                                               logic [31:0] nv, int sidx);
    table_result_t r;
    probe_res_t pr;
    int pos, start;
    r = '0;
    r.status = lph_pkg::ST_MISS;
    case (op) inside
      lph_pkg::OP_LOOKUP, lph_pkg::OP_INSERT, lph_pkg::OP_WRITE: begin
        pr = walk(k, op != lph_pkg::OP_LOOKUP, pos, start);
        if (pr == PRB_HIT) begin
          r.status = lph_pkg::ST_FOUND;
          if (op == lph_pkg::OP_WRITE) shadow_vals[pos] = nv;
          r.value = shadow_vals[pos];
          r.key = shadow_keys[pos];
          r.slot = 6'(pos);
        end else if (pr == PRB_EMPTY) begin
          if (k == 0) begin
            zkey_valid = 1;
            zkey_slot = pos;
          end
          shadow_keys[pos] = k;
          shadow_vals[pos] = (op == lph_pkg::OP_WRITE) ? nv : 32'd0;
          fill_count++;
          run_check(start, pos);
          r.status = lph_pkg::ST_INSERTED;
          r.value = shadow_vals[pos];
          r.key = k;
          r.slot = 6'(pos);
        end else if (pr == PRB_FULL && op != lph_pkg::OP_LOOKUP) begin
          r.status = lph_pkg::ST_FULL;
        end
      end
      lph_pkg::OP_REMOVE: begin
        pr = walk(k, 0, pos, start);
        if (pr == PRB_HIT) begin
          r.status = lph_pkg::ST_FOUND;
          r.value = shadow_vals[pos];
          r.key = shadow_keys[pos];
          r.slot = 6'(pos);
          shift_out(pos);
        end
      end
      lph_pkg::OP_CLEAR: begin
        foreach (shadow_keys[i]) shadow_keys[i] = 0;
        zkey_valid = 0;
        zkey_slot = 0;
        fill_count = 0;
        rehash_flag = 0;
        r.status = lph_pkg::ST_FOUND;
      end
      lph_pkg::OP_SCAN: begin
        for (int i = sidx; i < 64; i++) begin
          if (shadow_keys[i] != 0 || zero_at(i)) begin
            r.status = lph_pkg::ST_FOUND;
            r.value = shadow_vals[i];
            r.key = shadow_keys[i];
            r.slot = 6'(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.rehash = rehash_flag;
    r.count = 7'(fill_count);
    return r;
  endfunction

  always @(posedge clk) begin
    table_result_t exp_r;
    if (rst) begin
      foreach (shadow_keys[i]) shadow_keys[i] = 0;
      zkey_valid = 0;
      zkey_slot = 0;
      fill_count = 0;
      rehash_flag = 0;
      probe_limit = int'(lph_pkg::PROBE_LIMIT_RST);
      load_thr = int'(lph_pkg::LOAD_THR_RST);
      result_fifo.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == lph_pkg::REG_PROBE_LIMIT) probe_limit = int'(cfg_data);
        else load_thr = int'(cfg_data);
      end
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_r = result_fifo.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            errors++;
          end
          if (value_out !== exp_r.value) begin
            $error("value_out: expected %h, got %h", exp_r.value, value_out);
            errors++;
          end
          if (key_out !== exp_r.key) begin
            $error("key_out: expected %h, got %h", exp_r.key, key_out);
            errors++;
          end
          if (slot_out !== exp_r.slot) begin
            $error("slot_out: expected %0d, got %0d", exp_r.slot, slot_out);
            errors++;
          end
          if (rehash_wanted !== exp_r.rehash) begin
            $error("rehash_wanted: expected %0d, got %0d", exp_r.rehash, rehash_wanted);
            errors++;
          end
          if (entry_count !== exp_r.count) begin
            $error("entry_count: expected %0d, got %0d", exp_r.count, entry_count);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        result_fifo.push_back(predict_op(opcode, key, store_value, int'(slot_index)));
    end
  end

endmodule

### dv/linear_probe_hash_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives directed and random table operations through several register
// settings, with bursty requests and a stalling result sink, and reports the
// verdict from the checker's error count.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;

  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  opcode = lph_pkg::OP_LOOKUP;
  logic [31:0] key = 0;
  logic [31:0] store_value = 0;
  logic [5:0]  slot_index = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [31:0] key_out;
  logic [5:0]  slot_out;
  logic        rehash_wanted;
  logic [6:0]  entry_count;
  logic        cfg_we = 0;
  logic        cfg_index = lph_pkg::REG_PROBE_LIMIT;
  logic [6:0]  cfg_data = 0;
  int          errors;
  int          outstanding;
  logic        beat_taken;
  int          cycles = 0;
  int          burst_left = 0;
  int          sink_left = 0;
  int          sink_mode = 0;
  logic [6:0]  limits [6] = '{7'd8, 7'd0, 7'd64, 7'd2, 7'd0, 7'd64};
  logic [6:0]  thrs [6]   = '{7'd48, 7'd0, 7'd64, 7'd10, 7'd64, 7'd0};

  always #5 clk = ~clk;

  linear_probe_hash_table dut (.*);

  lph_checker u_checker (.*);

  always @(posedge clk) begin
    beat_taken <= in_valid && in_ready;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sink: long ready, coin-flip, and long stall stretches
  always @(negedge clk) begin
    if (sink_left == 0) begin
      sink_mode = $urandom_range(0, 2);
      sink_left = $urandom_range(1, 40);
    end
    sink_left--;
    case (sink_mode)
      0: out_ready = 1;
      1: out_ready = $urandom_range(0, 1);
      default: out_ready = (sink_left % 9 == 0);
    endcase
  end

  task automatic send(logic [2:0] op, logic [31:0] k, logic [31:0] nv, logic [5:0] si);
    int gap;
    if (burst_left == 0) begin
      in_valid = 0;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid = 1;
    opcode = op;
    key = k;
    store_value = nv;
    slot_index = si;
    do @(negedge clk); while (!beat_taken);
  endtask

  task automatic drain();
    in_valid = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_regs(logic [6:0] limit, logic [6:0] thr);
    cfg_we = 1;
    cfg_index = lph_pkg::REG_PROBE_LIMIT;
    cfg_data = limit;
    @(negedge clk);
    cfg_index = lph_pkg::REG_LOAD_THR;
    cfg_data = thr;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // mostly keys crowding the slots around the wrap point
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return ($urandom_range(0, 31) << 6) | ((58 + $urandom_range(0, 11)) % 64);
    endcase
  endfunction

  task automatic random_op();
    int pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = lph_pkg::OP_INSERT;
    else if (pick < 50) op = lph_pkg::OP_WRITE;
    else if (pick < 68) op = lph_pkg::OP_LOOKUP;
    else if (pick < 88) op = lph_pkg::OP_REMOVE;
    else if (pick < 96) op = lph_pkg::OP_SCAN;
    else if (pick < 97) op = lph_pkg::OP_CLEAR;
    else op = $urandom_range(0, 1) ? OP_BAD6 : OP_BAD7;
    send(op, pick_key(), $urandom, 6'($urandom_range(0, 63)));
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst = 0;
    set_regs(7'd8, 7'd48);

    send(lph_pkg::OP_CLEAR, 0, 0, 0);
    send(lph_pkg::OP_LOOKUP, 0, 0, 0);
    send(lph_pkg::OP_INSERT, 0, 0, 0);
    send(lph_pkg::OP_LOOKUP, 0, 0, 0);
    send(lph_pkg::OP_WRITE, 0, 32'hffff_ffff, 0);
    send(lph_pkg::OP_INSERT, 32'd64, 0, 0);
    send(lph_pkg::OP_LOOKUP, 32'd64, 0, 0);
    send(lph_pkg::OP_SCAN, 0, 0, 6'd0);
    send(lph_pkg::OP_SCAN, 0, 0, 6'd63);
    send(lph_pkg::OP_REMOVE, 0, 0, 0);
    send(lph_pkg::OP_LOOKUP, 32'd64, 0, 0);
    send(lph_pkg::OP_REMOVE, 0, 0, 0);
    send(lph_pkg::OP_WRITE, 32'hffff_ffff, 32'h8000_0000, 0);
    send(lph_pkg::OP_WRITE, 32'h8000_0000, 32'h7fff_ffff, 0);
    send(lph_pkg::OP_WRITE, 32'h7fff_ffff, 32'h0, 0);
    send(lph_pkg::OP_SCAN, 0, 0, 6'd63);
    send(lph_pkg::OP_REMOVE, 32'h7fff_ffff, 0, 0);
    send(lph_pkg::OP_REMOVE, 32'h0000_0040, 0, 0);
    send(OP_BAD6, $urandom, $urandom, 6'd63);
    send(OP_BAD7, $urandom, $urandom, 6'd0);
    send(lph_pkg::OP_SCAN, 0, 0, 6'd1);
    send(lph_pkg::OP_CLEAR, 0, 0, 0);
    drain();

    // fill past capacity, hit full on insert and write, then empty it again
    set_regs(7'd0, 7'd0);
    for (int i = 0; i < 68; i++)
      send(lph_pkg::OP_INSERT, 32'((i << 7) | ((60 + i) % 64)), 0, 0);
    send(lph_pkg::OP_WRITE, 32'h1234_5678, $urandom, 0);
    send(lph_pkg::OP_LOOKUP, 32'h1234_5678, 0, 0);
    send(lph_pkg::OP_SCAN, 0, 0, 6'd5);
    for (int i = 0; i < 68; i++)
      send(lph_pkg::OP_REMOVE, 32'((i << 7) | ((60 + i) % 64)), 0, 0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph < 6) set_regs(limits[ph], thrs[ph]);
      else set_regs(7'($urandom_range(0, 64)), 7'($urandom_range(0, 64)));
      send(lph_pkg::OP_CLEAR, 0, 0, 0);
      // grow a dense table before the mixed traffic
      for (int i = 0; i < 40; i++)
        send($urandom_range(0, 1) ? lph_pkg::OP_INSERT : lph_pkg::OP_WRITE, pick_key(),
             $urandom, 0);
      for (int i = 0; i < 146; i++) random_op();
      drain();
    end

    if (errors == 0 && outstanding == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
